FILE: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator: item kind codes,
// fixed port widths and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Fixed port widths
    localparam int KIND_W  = 2;
    localparam int PAGE_W  = 15;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 16;

    // Reset value of the page total register
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd32768;

    // Item kind codes
    localparam logic [KIND_W-1:0] KIND_ALLOC     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK_USED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK_FREE = 2'd2;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;        // latch a new item
        logic clear_step;    // write one all-ones word during the clearing pass
        logic scan_read;     // read the next bitmap word of an allocate scan
        logic alloc_commit;  // set the free bit found and report it
        logic alloc_fail;    // report out of memory
        logic mark_read;     // read the word holding the marked page
        logic mark_commit;   // update the marked page and report it
        logic nop_done;      // report an item with no operation
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;    // clearing pass is on its last word
        logic word_free;     // word just read has a free page
        logic scan_more;     // words remain to be read in this scan
    } t_sts;

endpackage

FILE: hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Control state machine: runs the clearing pass after reset, takes items and
// sequences the allocate scan and the mark read-modify-write.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [bpa_pkg::KIND_W-1:0]  i_kind,
    input  bpa_pkg::t_sts               i_sts,
    output bpa_pkg::t_cmd               o_cmd,
    output logic                        o_busy
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_NOP
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    case (i_kind)
                        bpa_pkg::KIND_ALLOC:     n_state = ST_SCAN;
                        bpa_pkg::KIND_MARK_USED: n_state = ST_MARK_RD;
                        bpa_pkg::KIND_MARK_FREE: n_state = ST_MARK_RD;
                        default:                 n_state = ST_NOP;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_sts.word_free) begin
                    o_cmd.alloc_commit = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_sts.scan_more) begin
                    o_cmd.scan_read = 1'b1;
                end else begin
                    o_cmd.alloc_fail = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_MARK_RD: begin
                o_cmd.mark_read = 1'b1;
                n_state = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                o_cmd.mark_commit = 1'b1;
                n_state = ST_IDLE;
            end
            ST_NOP: begin
                o_cmd.nop_done = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: hw/rtl/bpa_dpath.sv
// ----------------------------------------------------------------------------
// bpa_dpath
// Datapath: usage bitmap memory, used-page counter, page total register,
// scan address, free-bit encoder and the result registers.
// ----------------------------------------------------------------------------
module bpa_dpath #(
    parameter int MAX_PAGES = 32768,
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpa_pkg::t_cmd                 i_cmd,
    output bpa_pkg::t_sts                 o_sts,
    input  logic [bpa_pkg::KIND_W-1:0]    i_kind,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_page_index,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::TOTAL_W-1:0]   i_cfg_wdata,
    output logic                          o_strobe,
    output logic                          o_status,
    output logic [bpa_pkg::PAGE_W-1:0]    o_result_page,
    output logic                          o_bit_changed,
    output logic [bpa_pkg::COUNT_W-1:0]   o_used_count
);

    localparam int WORD_COUNT = MAX_PAGES / WORD_BITS;
    localparam int AW  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int SW  = AW + 1;
    localparam int BW  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int CW  = $clog2(MAX_PAGES + 1);
    localparam int LW  = (CW > bpa_pkg::TOTAL_W) ? CW : bpa_pkg::TOTAL_W;
    localparam int IXW = (AW > bpa_pkg::PAGE_W) ? AW : bpa_pkg::PAGE_W;
    localparam int RW  = (CW > bpa_pkg::PAGE_W) ? CW : bpa_pkg::PAGE_W;
    localparam logic [WORD_BITS-1:0] WORD_FULL = {WORD_BITS{1'b1}};

    logic [WORD_BITS-1:0]        r_mem [WORD_COUNT];
    logic [WORD_BITS-1:0]        r_rdata;
    logic [bpa_pkg::TOTAL_W-1:0] r_total;
    logic [bpa_pkg::KIND_W-1:0]  r_kind;
    logic [bpa_pkg::PAGE_W-1:0]  r_page;
    logic [LW-1:0]               r_words;
    logic [SW-1:0]               r_scan_addr;
    logic [SW-1:0]               r_clr_addr;
    logic [AW-1:0]               r_data_addr;
    logic                        r_rd_valid;
    logic [CW-1:0]               r_count;
    logic                        r_strobe;
    logic                        r_status;
    logic [RW-1:0]               r_res_page;
    logic                        r_changed;

    logic [LW-1:0]               limit;
    logic [LW-1:0]               words;
    logic [IXW-1:0]              page_ext;
    logic [IXW-1:0]              mark_word;
    logic [IXW-1:0]              mark_rem;
    logic [AW-1:0]               mark_addr;
    logic [BW-1:0]               mark_bit;
    logic                        mark_in_range;
    logic                        mark_want;
    logic                        mark_chg;
    logic [BW-1:0]               free_bit;
    logic [RW-1:0]               found_page;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [WORD_BITS-1:0]        wr_data;

    // Words searched by allocate: whole words below the clamped page total
    assign limit = (LW'(r_total) > LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : LW'(r_total);
    assign words = LW'(limit / WORD_BITS);

    // Locate the marked page
    assign page_ext      = IXW'(r_page);
    assign mark_word     = IXW'(page_ext / WORD_BITS);
    assign mark_rem      = IXW'(page_ext % WORD_BITS);
    assign mark_addr     = mark_word[AW-1:0];
    assign mark_bit      = mark_rem[BW-1:0];
    assign mark_in_range = (32'(r_page) < 32'(MAX_PAGES));
    assign mark_want     = (r_kind == bpa_pkg::KIND_MARK_USED);
    assign mark_chg      = mark_in_range && (r_rdata[mark_bit] != mark_want);

    // Find the lowest free page in the word just read
    always_comb begin
        free_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!r_rdata[i]) begin
                free_bit = BW'(i);
            end
        end
    end

    assign found_page = RW'(r_data_addr) * RW'(WORD_BITS) + RW'(free_bit);

    // Select the memory read port
    assign rd_en   = i_cmd.scan_read || i_cmd.mark_read;
    assign rd_addr = i_cmd.scan_read ? r_scan_addr[AW-1:0] : mark_addr;

    // Select the memory write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_addr[AW-1:0];
        wr_data = WORD_FULL;
        if (i_cmd.clear_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.alloc_commit) begin
            wr_en   = 1'b1;
            wr_addr = r_data_addr;
            wr_data = r_rdata | (WORD_BITS'(1) << free_bit);
        end else if (i_cmd.mark_commit) begin
            wr_en   = mark_chg;
            wr_addr = mark_addr;
            wr_data = mark_want ? (r_rdata | (WORD_BITS'(1) << mark_bit))
                                : (r_rdata & ~(WORD_BITS'(1) << mark_bit));
        end
    end

    // Bitmap memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Latch the item and track the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_page  <= i_page_index;
            r_words <= words;
        end
        if (i_cmd.scan_read) begin
            r_data_addr <= r_scan_addr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_rd_valid  <= 1'b0;
            r_clr_addr  <= '0;
            r_total     <= bpa_pkg::TOTAL_RESET;
        end else begin
            if (i_cmd.accept) begin
                r_scan_addr <= '0;
            end else if (i_cmd.scan_read) begin
                r_scan_addr <= r_scan_addr + SW'(1);
            end
            r_rd_valid <= i_cmd.scan_read;
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + SW'(1);
            end
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
        end
    end

    // Count used pages and drive the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CW'(MAX_PAGES);
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.alloc_commit || i_cmd.alloc_fail
                     || i_cmd.mark_commit || i_cmd.nop_done;
            if (i_cmd.alloc_commit) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.mark_commit && mark_chg) begin
                r_count <= mark_want ? (r_count + CW'(1)) : (r_count - CW'(1));
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_commit) begin
            r_status   <= bpa_pkg::STATUS_OK;
            r_res_page <= found_page;
            r_changed  <= 1'b1;
        end else if (i_cmd.alloc_fail) begin
            r_status   <= bpa_pkg::STATUS_OOM;
            r_res_page <= '0;
            r_changed  <= 1'b0;
        end else if (i_cmd.mark_commit) begin
            r_status   <= bpa_pkg::STATUS_OK;
            r_res_page <= RW'(r_page);
            r_changed  <= mark_chg;
        end else if (i_cmd.nop_done) begin
            r_status   <= bpa_pkg::STATUS_OK;
            r_res_page <= RW'(r_page);
            r_changed  <= 1'b0;
        end
    end

    // Status to the controller
    assign o_sts.clear_last = (r_clr_addr == SW'(WORD_COUNT - 1));
    assign o_sts.word_free  = r_rd_valid && (r_rdata != WORD_FULL);
    assign o_sts.scan_more  = (LW'(r_scan_addr) < r_words);

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_result_page = r_res_page[bpa_pkg::PAGE_W-1:0];
    assign o_bit_changed = r_changed;
    assign o_used_count  = bpa_pkg::COUNT_W'(r_count);

endmodule

FILE: hw/rtl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit bitmap page allocator with mark-used / mark-free operations.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that writes every bitmap word to
// all ones, one word per cycle, with busy high. An item is taken when start is
// high and busy is low; its single result appears on the o_ ports for one
// cycle with o_strobe and cannot be held off, so the receiver must take it
// then. A mark item reads the word holding its page, then writes it back;
// an item of the unused kind leaves the bitmap as it is. Allocate reads one
// bitmap word per cycle through the memory's single read port, from word 0
// up, until a word with a free page is found or all searchable words are
// read and full. A new item can be taken in the cycle its result is on the
// strobe. Configuration writes to the page total are accepted at any edge
// but belong in idle periods.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
    parameter int MAX_PAGES = 32768,
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bpa_pkg::KIND_W-1:0]    i_kind,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_page_index,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::TOTAL_W-1:0]   i_cfg_wdata,
    output logic                          o_strobe,
    output logic                          o_status,
    output logic [bpa_pkg::PAGE_W-1:0]    o_result_page,
    output logic                          o_bit_changed,
    output logic [bpa_pkg::COUNT_W-1:0]   o_used_count
);

    bpa_pkg::t_cmd cmd;
    bpa_pkg::t_sts sts;

    // Sequence items
    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Hold bitmap, count and results
    bpa_dpath #(
        .MAX_PAGES (MAX_PAGES),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_page_index  (i_page_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_result_page (o_result_page),
        .o_bit_changed (o_bit_changed),
        .o_used_count  (o_used_count)
    );

endmodule

FILE: hw/rtl/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks for the bitmap page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_strobe,
    input  logic                          o_status,
    input  logic [bpa_pkg::PAGE_W-1:0]    o_result_page,
    input  logic                          o_bit_changed,
    input  logic [bpa_pkg::COUNT_W-1:0]   o_used_count
);

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without work in progress");

    // Out of memory reports page zero and no change
    a_oom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == bpa_pkg::STATUS_OOM)
            |-> (!o_bit_changed && o_result_page == '0))
        else $error("out of memory result carries a page or a change");

    // The used count moves only with a result
    a_count_moves_on_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && o_used_count != $past(o_used_count)) |-> o_strobe)
        else $error("used count changed without a result");

    // A changed bit moves the count by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_bit_changed)
            |-> (o_used_count == bpa_pkg::COUNT_W'($past(o_used_count) + 1'b1)
              || o_used_count == bpa_pkg::COUNT_W'($past(o_used_count) - 1'b1)))
        else $error("used count did not step by one on a changed bit");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_status      (o_status),
    .o_result_page (o_result_page),
    .o_bit_changed (o_bit_changed),
    .o_used_count  (o_used_count)
);

FILE: verif/bpa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpa_tb_checker
// Watches the item, configuration and result ports of the page allocator,
// keeps its own copy of the usage bitmap, used count and page total, predicts
// the result of every accepted item and compares it with what comes out.
// ----------------------------------------------------------------------------
module bpa_tb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [bpa_pkg::KIND_W-1:0]    i_kind,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_page_index,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::TOTAL_W-1:0]   i_cfg_wdata,
    input  logic                          i_strobe,
    input  logic                          i_status,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_result_page,
    input  logic                          i_bit_changed,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_used_count,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int PAGES      = 32768;
    localparam int WORD_W     = 32;
    localparam int WORDS      = PAGES / WORD_W;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic                        status;
        logic [bpa_pkg::PAGE_W-1:0]  page;
        logic                        changed;
        logic [bpa_pkg::COUNT_W-1:0] count;
    } t_page_result;

    // Shadow of the allocator state
    logic [WORD_W-1:0]           page_map [WORDS];
    int unsigned                 used_pages;
    logic [bpa_pkg::TOTAL_W-1:0] total_pages;

    t_page_result       pending_results [$];
    t_page_result       want;
    t_page_result       got;

    // Apply one item to the shadow state and return the result it should give
    function automatic t_page_result apply_item(logic [bpa_pkg::KIND_W-1:0] kind,
                                                logic [bpa_pkg::PAGE_W-1:0] page);
        t_page_result r;
        int unsigned  reach;
        int unsigned  words;
        int           w;
        int           b;
        logic         found;
        logic         mark_to;
        r.status  = bpa_pkg::STATUS_OK;
        r.page    = page;
        r.changed = 1'b0;
        found     = 1'b0;
        case (kind)
            bpa_pkg::KIND_ALLOC: begin
                reach  = (total_pages > PAGES) ? PAGES : total_pages;
                words  = reach / WORD_W;
                r.page = '0;
                // First fit: skip full words, take the lowest clear bit
                for (w = 0; w < int'(words) && !found; w++) begin
                    if (page_map[w] != '1) begin
                        for (b = 0; b < WORD_W && !found; b++) begin
                            if (!page_map[w][b]) begin
                                page_map[w][b] = 1'b1;
                                used_pages++;
                                r.page    = bpa_pkg::PAGE_W'(w * WORD_W + b);
                                r.changed = 1'b1;
                                found     = 1'b1;
                            end
                        end
                    end
                end
                if (!found)
                    r.status = bpa_pkg::STATUS_OOM;
            end
            bpa_pkg::KIND_MARK_USED, bpa_pkg::KIND_MARK_FREE: begin
                mark_to = (kind == bpa_pkg::KIND_MARK_USED);
                if (int'(page) < PAGES
                        && page_map[page / WORD_W][page % WORD_W] != mark_to) begin
                    page_map[page / WORD_W][page % WORD_W] = mark_to;
                    if (mark_to)
                        used_pages++;
                    else
                        used_pages--;
                    r.changed = 1'b1;
                end
            end
            default: begin
                // unused kind: echo only
            end
        endcase
        r.count = bpa_pkg::COUNT_W'(used_pages);
        return r;
    endfunction

    // Track reset, configuration, results and accepted items at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WORDS; i++)
                page_map[i] = '1;
            used_pages  = PAGES;
            total_pages = bpa_pkg::TOTAL_RESET;
            pending_results.delete();
            o_pending    = 0;
            o_fail_count = 0;
        end else begin
            // Compare the result on the strobe with the oldest prediction
            if (i_strobe) begin
                got = '{i_status, i_result_page, i_bit_changed, i_used_count};
                if (pending_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("%0t: result with nothing pending: %s%0d %0d %0d %0d",
                                 $time, "st/pg/chg/cnt ",
                                 got.status, got.page, got.changed, got.count);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.page !== want.page ||
                        got.changed !== want.changed || got.count !== want.count) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX)
                            $display("%0t: mismatch exp st=%0d pg=%0d chg=%0d cnt=%0d,",
                                     $time, want.status, want.page, want.changed,
                                     want.count,
                                     " got st=%0d pg=%0d chg=%0d cnt=%0d",
                                     got.status, got.page, got.changed, got.count);
                    end
                end
            end
            if (i_cfg_we)
                total_pages = i_cfg_wdata;
            if (i_start && !i_busy)
                pending_results.push_back(apply_item(i_kind, i_page_index));
            o_pending = pending_results.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the bitmap page allocator with a directed opening (full-bitmap
// allocate, first and last page, partial last word, zero and oversized page
// totals, repeated marks, the unused kind) and then with randomized phases at
// several page totals, sent in bursts with random gaps. The checker predicts
// and compares; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [bpa_pkg::KIND_W-1:0] KIND_NOP = 2'd3;
    localparam int IDLE_LIMIT  = 6000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 70;
    localparam int LAST_PAGE   = 32767;
    localparam int PAGES       = 32768;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          start        = 1'b0;
    logic                          busy;
    logic [bpa_pkg::KIND_W-1:0]    i_kind       = bpa_pkg::KIND_ALLOC;
    logic [bpa_pkg::PAGE_W-1:0]    i_page_index = '0;
    logic                          i_cfg_we     = 1'b0;
    logic [bpa_pkg::TOTAL_W-1:0]   i_cfg_wdata  = '0;
    logic                          o_strobe;
    logic                          o_status;
    logic [bpa_pkg::PAGE_W-1:0]    o_result_page;
    logic                          o_bit_changed;
    logic [bpa_pkg::COUNT_W-1:0]   o_used_count;

    int                            fail_count;
    int                            pending;
    int                            idle_cycles = 0;
    int                            burst_left  = 0;
    int                            gap;
    int                            roll;
    int unsigned                   reach;
    logic [bpa_pkg::TOTAL_W-1:0]   total;
    logic [bpa_pkg::KIND_W-1:0]    kind;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    bitmap_page_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_page_index  (i_page_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_result_page (o_result_page),
        .o_bit_changed (o_bit_changed),
        .o_used_count  (o_used_count)
    );

    bpa_tb_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (i_kind),
        .i_page_index  (i_page_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_strobe      (o_strobe),
        .i_status      (o_status),
        .i_result_page (o_result_page),
        .i_bit_changed (o_bit_changed),
        .i_used_count  (o_used_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Present one item and hold it until the block takes it
    task automatic send_item(input logic [bpa_pkg::KIND_W-1:0] k, input int unsigned pg);
        start        <= 1'b1;
        i_kind       <= k;
        i_page_index <= bpa_pkg::PAGE_W'(pg);
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Drop start and wait until the block is idle with no result outstanding
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge i_clk);
        while (busy || pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_total(input logic [bpa_pkg::TOTAL_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly low pages where allocation is busy, some near the search limit,
    // the rest anywhere
    function automatic int unsigned pick_page(int unsigned lim);
        int unsigned r;
        int unsigned p;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            p = $urandom_range(0, 159);
        end else if (r < 80) begin
            p = ((lim >= 32) ? lim - 32 : 0) + $urandom_range(0, 63);
            if (p > LAST_PAGE)
                p = LAST_PAGE;
        end else begin
            p = $urandom_range(0, LAST_PAGE);
        end
        return p;
    endfunction

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        // Directed: everything starts used at the reset page total
        send_item(bpa_pkg::KIND_ALLOC, 0);
        send_item(bpa_pkg::KIND_MARK_FREE, 0);
        send_item(bpa_pkg::KIND_MARK_FREE, 0);
        send_item(bpa_pkg::KIND_ALLOC, LAST_PAGE);
        send_item(bpa_pkg::KIND_ALLOC, 0);
        send_item(bpa_pkg::KIND_MARK_FREE, LAST_PAGE);
        send_item(bpa_pkg::KIND_MARK_USED, LAST_PAGE - 1);
        send_item(bpa_pkg::KIND_ALLOC, 0);
        send_item(bpa_pkg::KIND_MARK_FREE, 5);
        send_item(bpa_pkg::KIND_MARK_USED, 5);
        send_item(KIND_NOP, LAST_PAGE);
        send_item(KIND_NOP, 0);
        send_item(bpa_pkg::KIND_MARK_FREE, 40);
        send_item(bpa_pkg::KIND_MARK_FREE, 33);
        send_item(bpa_pkg::KIND_ALLOC, 0);

        // Partial last word: pages 96..99 are never handed out
        drain();
        write_total(16'd100);
        send_item(bpa_pkg::KIND_MARK_FREE, 97);
        send_item(bpa_pkg::KIND_ALLOC, 0);
        send_item(bpa_pkg::KIND_MARK_FREE, 95);
        send_item(bpa_pkg::KIND_ALLOC, 0);
        send_item(bpa_pkg::KIND_MARK_USED, 97);

        // Zero total: no word is searched
        drain();
        write_total(16'd0);
        send_item(bpa_pkg::KIND_MARK_FREE, 3);
        send_item(bpa_pkg::KIND_ALLOC, 0);

        // Oversized total is clamped to the store size
        drain();
        write_total(16'hFFFF);
        send_item(bpa_pkg::KIND_ALLOC, 0);

        // Less than one whole word
        drain();
        write_total(16'd31);
        send_item(bpa_pkg::KIND_MARK_FREE, 1);
        send_item(bpa_pkg::KIND_ALLOC, LAST_PAGE);
        send_item(bpa_pkg::KIND_MARK_USED, 1);

        // Random phases, each at its own page total
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0:       total = 16'd256;
                1:       total = 16'd32768;
                2:       total = 16'd64;
                3:       total = 16'hFFFF;
                4:       total = 16'd200;
                5:       total = 16'd4096;
                6:       total = 16'd0;
                default: total = bpa_pkg::TOTAL_W'($urandom_range(0, 65535));
            endcase
            write_total(total);
            reach = (total > PAGES) ? PAGES : total;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    kind = bpa_pkg::KIND_ALLOC;
                else if (roll < 75)
                    kind = bpa_pkg::KIND_MARK_FREE;
                else if (roll < 93)
                    kind = bpa_pkg::KIND_MARK_USED;
                else
                    kind = KIND_NOP;
                send_item(kind, pick_page(reach));
                // Advance the burst; at its end, idle for a random gap
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        start <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end

        drain();
        repeat (64) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
